>>> rtl/bqs_pkg.sv
// Shared constants and types for the bounded queue server.
// No dependencies; imported by bounded_queue_server_sim.
package bqs_pkg;

  localparam int QUEUE_DEPTH = 32;                       // waiting slots, 1..63
  localparam int ID_W        = 20;
  localparam int TIME_W      = 48;
  localparam int DUR_W       = 32;
  localparam int LIMIT_W     = 6;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [DUR_W-1:0]  dur;
  } wait_entry_t;

  localparam int ENTRY_W = $bits(wait_entry_t);

endpackage

>>> rtl/bounded_queue_server_sim.sv
// Single server with a bounded FIFO of waiting jobs.
// Depends on bqs_pkg and bqs_ram.
//
// Usage:
//   Input channel (in_valid/in_ready): func 0 is a job arrival with job_id,
//   arrive_time and duration; func 1 flushes every waiting job.
//   Output channel (out_valid/out_ready): one item per completed or rejected
//   job; last_result marks the final item caused by an input item. A queued
//   arrival with nothing drained, or a flush of an empty queue, gives none.
//   Config channel (cfg_valid/cfg_ready): writes queue_limit; cfg_ready is
//   always high. Write only while the block is idle.
// Timing:
//   One item is in work at a time; in_ready is high only when idle.
//   Each drained job goes through decide/read, compare and saturating add
//   (CHECK, DRAIN, ADD) on the shared compare and adder; reads are registered.
//   A flush or a queued arrival goes from CHECK back to IDLE; an arrival that
//   starts at once or is rejected goes on to START or REJ first.
// Reset clears the server time, queue pointers and count, and sets
// queue_limit to 32. When the receiver stalls the sequencer holds the
// finished item in the output register and waits.
module bounded_queue_server_sim
  import bqs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  queue_limit,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [ID_W-1:0]     job_id,
  input  logic [TIME_W-1:0]   arrive_time,
  input  logic [DUR_W-1:0]    duration,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     result_id,
  output logic [TIME_W-1:0]   finish_time,
  output logic                rejected,
  output logic                last_result
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DRAIN,
    S_ADD,
    S_START,
    S_REJ
  } state_t;

  state_t             state;
  logic [LIMIT_W-1:0] limit_cfg;
  logic [TIME_W-1:0]  server_free_time;
  logic [IDX_W-1:0]   head_index;
  logic [CNT_W-1:0]   wait_count;

  // latched input item
  logic               func_r;
  logic [ID_W-1:0]    id_r;
  logic [TIME_W-1:0]  t_r;
  logic [DUR_W-1:0]   d_r;
  logic [CNT_W-1:0]   lim_r;

  // drained job awaiting its last flag
  logic               pend_valid;
  logic [ID_W-1:0]    pend_id;
  logic [TIME_W-1:0]  pend_fin;
  logic [TIME_W-1:0]  start_time;

  // RAM
  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   tail_index;
  wait_entry_t        wr_entry;
  wait_entry_t        rd_entry;
  logic [ENTRY_W-1:0] rd_bits;

  // shared compare and saturating adder
  logic [TIME_W-1:0]  cmp_b;
  logic               sft_gt;
  logic [TIME_W-1:0]  add_a;
  logic [DUR_W-1:0]   add_b;
  logic [TIME_W:0]    add_sum;
  logic [TIME_W-1:0]  add_sat;

  logic               out_free;
  logic               more;
  logic               can_queue;
  logic               final_res;
  logic [CNT_W-1:0]   lim_eff;
  logic [CNT_W:0]     tail_sum;
  logic [IDX_W-1:0]   head_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign lim_eff = (limit_cfg > LIMIT_W'(QUEUE_DEPTH)) ? CNT_W'(QUEUE_DEPTH)
                                                        : CNT_W'(limit_cfg);

  assign rd_entry = wait_entry_t'(rd_bits);

  assign cmp_b   = (state == S_DRAIN) ? rd_entry.arrival : t_r;
  assign sft_gt  = server_free_time > cmp_b;
  assign add_a   = (state == S_ADD) ? start_time : t_r;
  assign add_b   = (state == S_ADD) ? rd_entry.dur : d_r;
  assign add_sum = {1'b0, add_a} + {{(TIME_W + 1 - DUR_W){1'b0}}, add_b};
  assign add_sat = add_sum[TIME_W] ? {TIME_W{1'b1}} : add_sum[TIME_W-1:0];

  // decisions taken in CHECK
  assign more      = (wait_count != '0) && (func_r || !sft_gt);
  assign can_queue = sft_gt && (wait_count < lim_r);
  assign final_res = !func_r && !more && !can_queue;

  assign tail_sum   = {1'b0, {(CNT_W - IDX_W){1'b0}}, head_index} + {1'b0, wait_count};
  assign tail_index = (tail_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                      : IDX_W'(tail_sum);
  assign head_next  = (head_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_index + 1'b1;

  assign ram_re = (state == S_CHECK) && (!pend_valid || out_free) && more;
  assign ram_we = (state == S_CHECK) && (!pend_valid || out_free) && !more
                  && !func_r && can_queue;
  assign wr_entry = '{id: id_r, arrival: t_r, dur: d_r};

  bqs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_wait_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_index),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (head_index),
    .rdata (rd_bits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      limit_cfg        <= LIMIT_RESET;
      server_free_time <= '0;
      head_index       <= '0;
      wait_count       <= '0;
      pend_valid       <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_cfg <= queue_limit;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_r <= func;
            id_r   <= job_id;
            t_r    <= arrive_time;
            d_r    <= duration;
            lim_r  <= lim_eff;
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_valid   <= 1'b1;
              result_id   <= pend_id;
              finish_time <= pend_fin;
              rejected    <= 1'b0;
              last_result <= !more && !final_res;
              pend_valid  <= 1'b0;
            end
            if (more) begin
              state <= S_DRAIN;
            end else if (func_r) begin
              state <= S_IDLE;
            end else if (sft_gt) begin
              if (can_queue) begin
                wait_count <= wait_count + 1'b1;
                state      <= S_IDLE;
              end else begin
                state <= S_REJ;
              end
            end else begin
              state <= S_START;
            end
          end
        end
        S_DRAIN: begin
          start_time <= sft_gt ? server_free_time : rd_entry.arrival;
          state      <= S_ADD;
        end
        S_ADD: begin
          server_free_time <= add_sat;
          pend_fin         <= add_sat;
          pend_id          <= rd_entry.id;
          pend_valid       <= 1'b1;
          head_index       <= head_next;
          wait_count       <= wait_count - 1'b1;
          state            <= S_CHECK;
        end
        S_START: begin
          if (out_free) begin
            server_free_time <= add_sat;
            out_valid        <= 1'b1;
            result_id        <= id_r;
            finish_time      <= add_sat;
            rejected         <= 1'b0;
            last_result      <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_REJ: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_id   <= id_r;
            finish_time <= '0;
            rejected    <= 1'b1;
            last_result <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    wait_count <= CNT_W'(QUEUE_DEPTH))
    else $error("wait count beyond queue depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head_index <= IDX_W'(QUEUE_DEPTH - 1))
    else $error("head index out of range");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("drained job left behind at idle");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> finish_time == '0 && last_result)
    else $error("rejected item with finish time or not last");

endmodule

>>> rtl/bqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
